>>> hw/rtl/redo_log_transaction_tracker_macros.svh
// Assertion macros for the redo log tracker RTL, included by rltt_back.
`ifndef REDO_LOG_TRANSACTION_TRACKER_MACROS_SVH
`define REDO_LOG_TRANSACTION_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLTT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLTT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rltt_pkg.sv
// Types, constants and register map of the redo log transaction tracker.
package rltt_pkg;

    localparam int TABLE_DEPTH_DEF = 30;
    localparam int OP_RESERVE_DEF  = 10;

    localparam int BLK_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int OPS_W    = 2;
    localparam int SIZE_W   = 11;
    localparam logic [OPS_W-1:0] OPS_MAX = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register map, word index
    localparam int REG_IDX_W = 1;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_LOG_START = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOG_SIZE  = 1'd1;

    localparam logic [BLK_W-1:0]  LOG_START_RST = 32'd2;
    localparam logic [SIZE_W-1:0] LOG_SIZE_RST  = 11'd30;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_END   = 2'd2,
        REQ_NOP   = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_WAIT     = 3'd1,
        ST_ABSORBED = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_OUTSIDE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_COPY   = 2'd1,
        CMD_HEADER = 2'd2
    } cmd_t;

    typedef struct packed {
        req_kind_t        kind;
        logic [BLK_W-1:0] blk;
    } item_t;

    typedef struct packed {
        status_t            status;
        cmd_t               command;
        logic [BLK_W-1:0]   src;
        logic [BLK_W-1:0]   dst;
        logic [COUNT_W-1:0] hdr_count;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [BLK_W-1:0]  log_start;
        logic [SIZE_W-1:0] log_size;
    } cfg_t;

endpackage

>>> hw/rtl/rltt_front.sv
// Request intake: decodes the request kind and holds it until the queue takes it.
module rltt_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rltt_pkg::BLK_W-1:0]  s_tdata,   // [31:0] block_number
    input  logic [1:0]                  s_tuser,   // [1:0] req_type
    output logic                        push_valid,
    input  logic                        push_ready,
    output rltt_pkg::item_t             push_item
);

    logic            hold_valid_reg, hold_valid_next;
    rltt_pkg::item_t hold_item_reg, hold_item_next;
    logic            s_accept;
    rltt_pkg::req_kind_t kind;

    assign s_tready = !hold_valid_reg || push_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        unique case (s_tuser)
            2'd0:    kind = rltt_pkg::REQ_BEGIN;
            2'd1:    kind = rltt_pkg::REQ_WRITE;
            2'd2:    kind = rltt_pkg::REQ_END;
            default: kind = rltt_pkg::REQ_NOP;
        endcase
    end

    always_comb begin
        hold_item_next  = hold_item_reg;
        hold_valid_next = hold_valid_reg;
        if (s_accept) begin
            hold_item_next.kind = kind;
            hold_item_next.blk  = s_tdata;
            hold_valid_next     = 1'b1;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_item_reg <= hold_item_next;
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule

>>> hw/rtl/rltt_queue.sv
// Short request queue between intake and execution.
module rltt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  rltt_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rltt_pkg::item_t pop_item
);

    rltt_pkg::item_t                q_mem_reg [rltt_pkg::QUEUE_DEPTH];
    logic [rltt_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rltt_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rltt_pkg::QPTR_W:0]     fill_reg, fill_next;
    logic                           do_push, do_pop;

    assign push_ready = fill_reg != (rltt_pkg::QPTR_W+1)'(rltt_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/rltt_back.sv
// Request execution: entry table, operation count, commit burst and result register.
`include "redo_log_transaction_tracker_macros.svh"

module rltt_back #(
    parameter int TABLE_DEPTH = rltt_pkg::TABLE_DEPTH_DEF,
    parameter int OP_RESERVE  = rltt_pkg::OP_RESERVE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rltt_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  rltt_pkg::item_t   pop_item,
    output logic              out_valid,
    input  logic              m_tready,
    output rltt_pkg::result_t out_res
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int NEED_W = $clog2(TABLE_DEPTH + 4 * OP_RESERVE + 1);
    localparam int CW     = rltt_pkg::COUNT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_RESP   = 7'b0000100,
        S_CP_OUT = 7'b0001000,
        S_HDR_N  = 7'b0010000,
        S_CP_IN  = 7'b0100000,
        S_HDR_Z  = 7'b1000000
    } state_t;

    logic [rltt_pkg::BLK_W-1:0] mem [TABLE_DEPTH];
    logic [rltt_pkg::BLK_W-1:0] rd_data_reg;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [rltt_pkg::OPS_W-1:0]      ops_reg, ops_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [rltt_pkg::BLK_W-1:0]      blk_reg, blk_next;
    rltt_pkg::status_t               resp_reg, resp_next;
    logic                            out_valid_reg, out_valid_next;
    rltt_pkg::result_t               out_res_reg;

    logic                            out_free, emit, rd_en, wr_en, hit, too_big;
    logic [IDX_W-1:0]                rd_addr;
    logic [CW-1:0]                   idx_inc;
    logic [NEED_W-1:0]               need;
    logic [rltt_pkg::BLK_W-1:0]      slot;
    rltt_pkg::result_t               res;

    assign out_free = !out_valid_reg || m_tready;
    assign idx_inc  = idx_reg + 1'b1;
    assign slot     = cfg.log_start + rltt_pkg::BLK_W'(idx_reg) + 32'd1;
    assign hit      = cmp_valid_reg && (rd_data_reg == blk_reg);
    assign need     = NEED_W'(count_reg)
                    + NEED_W'(OP_RESERVE) * (NEED_W'(ops_reg) + NEED_W'(1));
    assign too_big  = (count_reg >= CW'(TABLE_DEPTH))
                   || (rltt_pkg::SIZE_W'(count_reg) + rltt_pkg::SIZE_W'(1) >= cfg.log_size);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ops_next       = ops_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        blk_next       = blk_reg;
        resp_next      = resp_reg;
        pop_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        emit           = 1'b0;
        res            = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    pop_ready  = 1'b1;
                    blk_next   = pop_item.blk;
                    state_next = S_RESP;
                    resp_next  = rltt_pkg::ST_OK;
                    unique case (pop_item.kind)
                        rltt_pkg::REQ_BEGIN: begin
                            if (ops_reg == rltt_pkg::OPS_MAX || need > NEED_W'(TABLE_DEPTH)) begin
                                resp_next = rltt_pkg::ST_WAIT;
                            end else begin
                                ops_next = ops_reg + 1'b1;
                            end
                        end
                        rltt_pkg::REQ_WRITE: begin
                            priority if (too_big) begin
                                resp_next = rltt_pkg::ST_TOO_BIG;
                            end else if (ops_reg == '0) begin
                                resp_next = rltt_pkg::ST_OUTSIDE;
                            end else begin
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        rltt_pkg::REQ_END: begin
                            if (ops_reg == '0) begin
                                resp_next = rltt_pkg::ST_OUTSIDE;
                            end else begin
                                ops_next = ops_reg - 1'b1;
                                if (ops_reg == 2'd1 && count_reg != '0) begin
                                    // last operation closed with entries logged: start the commit burst
                                    idx_next   = '0;
                                    rd_en      = 1'b1;
                                    rd_addr    = '0;
                                    state_next = S_CP_OUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                // one table read issued per cycle, compared in the cycle after
                priority if (hit) begin
                    resp_next  = rltt_pkg::ST_ABSORBED;
                    state_next = S_RESP;
                end else if (idx_reg < count_reg) begin
                    rd_en          = 1'b1;
                    idx_next       = idx_inc;
                    cmp_valid_next = 1'b1;
                end else if (!cmp_valid_reg) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    resp_next  = rltt_pkg::ST_OK;
                    state_next = S_RESP;
                end else begin
                    cmp_valid_next = 1'b0;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res.status = resp_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CP_OUT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.command = rltt_pkg::CMD_COPY;
                    res.src     = rd_data_reg;
                    res.dst     = slot;
                    if (idx_inc == count_reg) begin
                        state_next = S_HDR_N;
                    end else begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_HDR_N: begin
                if (out_free) begin
                    emit          = 1'b1;
                    res.command   = rltt_pkg::CMD_HEADER;
                    res.hdr_count = count_reg;
                    idx_next      = '0;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    state_next    = S_CP_IN;
                end
            end
            S_CP_IN: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.command = rltt_pkg::CMD_COPY;
                    res.src     = slot;
                    res.dst     = rd_data_reg;
                    if (idx_inc == count_reg) begin
                        state_next = S_HDR_Z;
                    end else begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_HDR_Z: begin
                if (out_free) begin
                    emit        = 1'b1;
                    res.command = rltt_pkg::CMD_HEADER;
                    res.last    = 1'b1;
                    count_next  = '0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ops_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ops_reg       <= ops_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        blk_reg  <= blk_next;
        resp_reg <= resp_next;
        if (emit) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= blk_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `RLTT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(TABLE_DEPTH),
        "entry count above table depth")
    `RLTT_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_tready, !emit,
        "result register overwritten while stalled")
    `RLTT_ASSERT_NEXT(a_commit_clears,
        emit && res.command == rltt_pkg::CMD_HEADER && res.last, count_reg == '0,
        "entry count not cleared after commit")

endmodule

>>> hw/rtl/redo_log_transaction_tracker.sv
// Redo log group-commit tracker: top level with configuration registers.
//
// Requests enter on the s_ stream (s_tuser = request kind, s_tdata = block number);
// results leave on the m_ stream, one or more per request, m_tlast on the final one.
// Each request (begin, write, end, no-op) gives one status result; an end that closes the
// last operation with n logged entries gives 2n+2 commit commands instead.
// Intake registers a request, a four-deep queue decouples it from execution, and
// the executor owns the entry table (single-port RAM, registered read).
// A begin/end request passes the intake register, the queue, the executor's response
// state and the result register; a write first searches the entry table (one table
// compare per cycle). The executor takes one request at a time, a write holds it for
// the search, and a commit burst delivers one command per cycle while m_tready is high.
// A stalled m_tready holds the result register; the executor then waits and the
// queue and intake keep taking requests until full.
// Reset (aresetn low, synchronous) empties queue and result register, clears the
// entry count and open operations and reloads the configuration defaults.
// APB: word 0 log_region_start, word 1 log_region_size; write only while idle.
module redo_log_transaction_tracker #(
    parameter int TABLE_DEPTH = rltt_pkg::TABLE_DEPTH_DEF,
    parameter int OP_RESERVE  = rltt_pkg::OP_RESERVE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] block_number
    input  logic [1:0]                   s_tuser,   // [1:0] req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,   // [2:0] status, [34:3] source_block,
                                                    // [66:35] dest_block, [71:67] header_count
    output logic [1:0]                   m_tuser,   // [1:0] command
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rltt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    rltt_pkg::cfg_t                      cfg_reg, cfg_next;
    logic [rltt_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                wr_req;
    logic                                push_valid, push_ready, pop_valid, pop_ready;
    rltt_pkg::item_t                     push_item, pop_item;
    rltt_pkg::result_t                   out_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rltt_pkg::ADDR_W-1:2];
    assign wr_req  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_req) begin
            unique case (reg_idx)
                rltt_pkg::REG_LOG_START: cfg_next.log_start = pwdata;
                rltt_pkg::REG_LOG_SIZE:  cfg_next.log_size  = pwdata[rltt_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rltt_pkg::REG_LOG_START: prdata = cfg_reg.log_start;
            rltt_pkg::REG_LOG_SIZE:  prdata = 32'(cfg_reg.log_size);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_start <= rltt_pkg::LOG_START_RST;
            cfg_reg.log_size  <= rltt_pkg::LOG_SIZE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rltt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rltt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rltt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .OP_RESERVE  (OP_RESERVE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .m_tready  (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.hdr_count, out_res.dst, out_res.src, out_res.status};
    assign m_tuser = out_res.command;
    assign m_tlast = out_res.last;

endmodule
